[rtl/core/masc_pkg.sv]
`default_nettype none

package masc_pkg;

    // request kinds carried on s_tuser
    typedef enum logic [2:0] {
        REQ_ADD       = 3'd0,
        REQ_DELETE    = 3'd1,
        REQ_EDIT      = 3'd2,
        REQ_SEC_TICK  = 3'd3,
        REQ_RING_TICK = 3'd4,
        REQ_STOP      = 3'd5
    } req_t;

    // result status codes
    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_EMPTY     = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

    // alarm slot mode
    typedef enum logic [1:0] {
        MODE_OFF  = 2'd0,
        MODE_RING = 2'd1,
        MODE_WAIT = 2'd2
    } mode_t;

    // configuration register indexes
    localparam logic [1:0] CFG_RING_TICKS  = 2'd0;
    localparam logic [1:0] CFG_WAIT_TICKS  = 2'd1;
    localparam logic [1:0] CFG_MAX_SNOOZES = 2'd2;

    // configuration reset values
    localparam logic [7:0] RING_TICKS_RST  = 8'd30;
    localparam logic [7:0] WAIT_TICKS_RST  = 8'd60;
    localparam logic [3:0] MAX_SNOOZES_RST = 4'd2;

    // counter saturation points
    localparam logic [7:0] TICK_CNT_MAX   = 8'hFF;
    localparam logic [4:0] SNOOZE_CNT_MAX = 5'd31;

    // port widths
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;
    localparam int CFG_DATA_W = 8;

    // one alarm slot as held in the slot ram
    typedef struct packed {
        logic [7:0]  key;
        logic [16:0] alarm_time;
        logic        active;
        logic        rpt;
        mode_t       mode;
        logic [7:0]  ring_cnt;
        logic [7:0]  wait_cnt;
        logic [4:0]  snooze_cnt;
    } slot_t;

    // request payload on s_tdata, lowest field last
    typedef struct packed {
        logic [3:0]  pad;
        logic [16:0] current_time;
        logic        alarm_repeat;
        logic        alarm_active;
        logic [16:0] alarm_time;
        logic [7:0]  alarm_key;
    } item_t;

    // result payload on m_tdata, lowest field last
    typedef struct packed {
        logic [4:0] pad;
        logic [3:0] used_slots;
        logic [2:0] fired_slot;
        logic       fired;
        logic       buzzer_on;
        status_t    status;
    } res_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_WALK_NEXT,
        S_SRCH,
        S_MOVE,
        S_DONE
    } fsm_state_t;

    // slot ram read address select
    typedef enum logic [1:0] {
        RD_ZERO,
        RD_IDX_NEXT,
        RD_SRCH_NEXT,
        RD_LAST
    } rd_sel_t;

    // slot ram write select
    typedef enum logic [2:0] {
        WR_NONE,
        WR_ADD,
        WR_EDIT,
        WR_FIRE,
        WR_TICK,
        WR_STOP,
        WR_MOVE
    } wr_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic    load;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        logic    idx_inc;
        logic    srch_inc;
        logic    srch_start;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    status_we;
        status_t status;
        logic    res_load;
    } dp_cmd_t;

    // datapath to controller status
    typedef struct packed {
        req_t req;
        logic cnt_zero;
        logic cnt_full;
        logic key_hit;
        logic time_hit;
        logic mode_off;
        logic mode_ring;
        logic rpt;
        logic idx_more;
        logic srch_more;
        logic out_free;
    } dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/masc_ram.sv]
`default_nettype none

module masc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                aclk,
    input  wire logic                we,
    input  wire logic [AW-1:0]       waddr,
    input  wire logic [WIDTH-1:0]    wdata,
    input  wire logic [AW-1:0]       raddr,
    output logic      [WIDTH-1:0]    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port, read returns old data on collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/core/masc_datapath.sv]
`default_nettype none

module masc_datapath
    import masc_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire dp_cmd_t               cmd,
    output dp_stat_t                   stat,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [S_TUSER_W-1:0]  s_tuser,
    input  wire logic                  cfg_valid,
    input  wire logic [1:0]            cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int SW = $bits(slot_t);

    // latched request
    req_t        req_reg;
    logic [7:0]  key_reg;
    logic [16:0] atime_reg;
    logic        act_reg;
    logic        rpt_reg;
    logic [16:0] now_reg;

    // table state and walk indexes
    logic [CW-1:0] cnt_reg;
    logic          buzzer_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] srch_reg;

    // configuration
    logic [7:0] ring_ticks_reg;
    logic [7:0] wait_ticks_reg;
    logic [3:0] max_snoozes_reg;

    // result
    status_t       status_reg;
    logic          fired_reg;
    logic [IW-1:0] fslot_reg;
    logic          m_tvalid_reg;
    res_t          m_tdata_reg;

    item_t         item;
    logic [CW-1:0] idx_plus;
    logic [CW-1:0] srch_plus;
    logic [IW-1:0] last_addr;
    logic [IW-1:0] raddr;
    logic [IW-1:0] waddr;
    logic          we;
    slot_t         wdata;
    slot_t         rdata;
    logic [SW-1:0] rdata_raw;
    slot_t         add_slot;
    slot_t         tick_slot;
    logic          tick_buz_on;
    logic          tick_buz_off;
    logic [7:0]    ring_limit;
    logic [CW+3:0] cnt_wide;
    logic [IW+2:0] fslot_wide;
    res_t          res;

    assign item = item_t'(s_tdata);

    // walk arithmetic
    assign idx_plus  = CW'(idx_reg) + CW'(1);
    assign srch_plus = CW'(srch_reg) + CW'(1);
    assign last_addr = IW'(cnt_reg - CW'(1));

    // read address select
    always_comb begin
        case (cmd.rd_sel)
            RD_ZERO:      raddr = '0;
            RD_IDX_NEXT:  raddr = IW'(idx_plus);
            RD_SRCH_NEXT: raddr = IW'(srch_plus);
            RD_LAST:      raddr = last_addr;
            default:      raddr = '0;
        endcase
    end

    // new slot for add
    always_comb begin
        add_slot            = '0;
        add_slot.key        = key_reg;
        add_slot.alarm_time = atime_reg;
        add_slot.active     = act_reg;
        add_slot.rpt        = rpt_reg;
        add_slot.mode       = MODE_OFF;
    end

    // ring tick update of one slot
    assign ring_limit = (ring_ticks_reg == 8'd0) ? 8'd1 : ring_ticks_reg;

    always_comb begin
        tick_slot    = rdata;
        tick_buz_on  = 1'b0;
        tick_buz_off = 1'b0;
        if (tick_slot.mode == MODE_RING && tick_slot.ring_cnt != TICK_CNT_MAX) begin
            tick_slot.ring_cnt = tick_slot.ring_cnt + 8'd1;
        end
        if (tick_slot.ring_cnt >= ring_limit) begin
            tick_slot.ring_cnt = 8'd0;
            tick_buz_off       = 1'b1;
            tick_slot.mode     = MODE_WAIT;
            if (tick_slot.snooze_cnt != SNOOZE_CNT_MAX) begin
                tick_slot.snooze_cnt = tick_slot.snooze_cnt + 5'd1;
            end
        end
        if (tick_slot.mode == MODE_WAIT) begin
            if (tick_slot.snooze_cnt > {1'b0, max_snoozes_reg}) begin
                tick_slot.mode       = MODE_OFF;
                tick_slot.snooze_cnt = 5'd0;
            end else begin
                if (tick_slot.wait_cnt != TICK_CNT_MAX) begin
                    tick_slot.wait_cnt = tick_slot.wait_cnt + 8'd1;
                end
                if (tick_slot.wait_cnt >= wait_ticks_reg) begin
                    tick_buz_on        = 1'b1;
                    tick_buz_off       = 1'b0;
                    tick_slot.mode     = MODE_RING;
                    tick_slot.wait_cnt = 8'd0;
                end
            end
        end
    end

    // write select
    always_comb begin
        we    = 1'b1;
        waddr = idx_reg;
        wdata = rdata;
        case (cmd.wr_sel)
            WR_NONE: begin
                we = 1'b0;
            end
            WR_ADD: begin
                waddr = IW'(cnt_reg);
                wdata = add_slot;
            end
            WR_EDIT: begin
                waddr            = srch_reg;
                wdata.alarm_time = atime_reg;
                wdata.active     = act_reg;
                wdata.rpt        = rpt_reg;
            end
            WR_FIRE: begin
                wdata.mode = MODE_RING;
            end
            WR_TICK: begin
                wdata = tick_slot;
            end
            WR_STOP: begin
                wdata.mode = MODE_OFF;
            end
            WR_MOVE: begin
                waddr = srch_reg;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    // slot table
    masc_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    assign rdata = slot_t'(rdata_raw);

    // latch request payload, or the slot key for a stop delete search
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= req_t'(s_tuser);
            key_reg   <= item.alarm_key;
            atime_reg <= item.alarm_time;
            act_reg   <= item.alarm_active;
            rpt_reg   <= item.alarm_repeat;
            now_reg   <= item.current_time;
        end else if (cmd.srch_start) begin
            key_reg <= rdata.key;
        end
    end

    // walk and search indexes
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            idx_reg  <= '0;
            srch_reg <= '0;
        end else begin
            if (cmd.idx_inc) begin
                idx_reg <= IW'(idx_plus);
            end
            if (cmd.srch_start) begin
                srch_reg <= '0;
            end else if (cmd.srch_inc) begin
                srch_reg <= IW'(srch_plus);
            end
        end
    end

    // alarm count and buzzer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= '0;
            buzzer_reg <= 1'b0;
        end else begin
            if (cmd.cnt_inc) begin
                cnt_reg <= cnt_reg + CW'(1);
            end else if (cmd.cnt_dec) begin
                cnt_reg <= cnt_reg - CW'(1);
            end
            if (cmd.wr_sel == WR_FIRE) begin
                buzzer_reg <= 1'b1;
            end else if (cmd.wr_sel == WR_STOP) begin
                buzzer_reg <= 1'b0;
            end else if (cmd.wr_sel == WR_TICK) begin
                if (tick_buz_on) begin
                    buzzer_reg <= 1'b1;
                end else if (tick_buz_off) begin
                    buzzer_reg <= 1'b0;
                end
            end
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_ticks_reg  <= RING_TICKS_RST;
            wait_ticks_reg  <= WAIT_TICKS_RST;
            max_snoozes_reg <= MAX_SNOOZES_RST;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_RING_TICKS:  ring_ticks_reg  <= cfg_data;
                CFG_WAIT_TICKS:  wait_ticks_reg  <= cfg_data;
                CFG_MAX_SNOOZES: max_snoozes_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // per-request result fields
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            status_reg <= STS_OK;
            fired_reg  <= 1'b0;
            fslot_reg  <= '0;
        end else begin
            if (cmd.status_we) begin
                status_reg <= cmd.status;
            end
            if (cmd.wr_sel == WR_FIRE) begin
                fired_reg <= 1'b1;
                fslot_reg <= idx_reg;
            end
        end
    end

    // result assembly
    assign cnt_wide   = {4'b0000, cnt_reg};
    assign fslot_wide = {3'b000, fslot_reg};

    always_comb begin
        res            = '0;
        res.status     = status_reg;
        res.buzzer_on  = buzzer_reg;
        res.fired      = fired_reg;
        res.fired_slot = fslot_wide[2:0];
        res.used_slots = cnt_wide[3:0];
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            m_tdata_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // status toward the controller
    always_comb begin
        stat           = '0;
        stat.req       = req_reg;
        stat.cnt_zero  = (cnt_reg == '0);
        stat.cnt_full  = (cnt_reg == CW'(SLOTS));
        stat.key_hit   = (rdata.key == key_reg);
        stat.time_hit  = rdata.active && (rdata.alarm_time == now_reg);
        stat.mode_off  = (rdata.mode == MODE_OFF);
        stat.mode_ring = (rdata.mode == MODE_RING);
        stat.rpt       = rdata.rpt;
        stat.idx_more  = (idx_plus < cnt_reg);
        stat.srch_more = (srch_plus < cnt_reg);
        stat.out_free  = !m_tvalid_reg || m_tready;
    end

endmodule

`default_nettype wire

[rtl/core/masc_ctrl.sv]
`default_nettype none

module masc_ctrl
    import masc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    fsm_state_t state_reg;
    fsm_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = aresetn;
                if (s_tvalid && aresetn) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH: begin
                state_next = S_DONE;
                case (stat.req)
                    REQ_ADD: begin
                        if (stat.cnt_full) begin
                            cmd.status_we = 1'b1;
                            cmd.status    = STS_FULL;
                        end else begin
                            cmd.wr_sel  = WR_ADD;
                            cmd.cnt_inc = 1'b1;
                        end
                    end
                    REQ_DELETE, REQ_EDIT: begin
                        if (stat.cnt_zero) begin
                            cmd.status_we = 1'b1;
                            cmd.status    = STS_EMPTY;
                        end else begin
                            cmd.rd_sel = RD_ZERO;
                            state_next = S_SRCH;
                        end
                    end
                    REQ_SEC_TICK, REQ_RING_TICK, REQ_STOP: begin
                        if (!stat.cnt_zero) begin
                            cmd.rd_sel = RD_ZERO;
                            state_next = S_WALK;
                        end
                    end
                    default: ;
                endcase
            end

            // one used slot per cycle, a stop delete holds it; next read overlaps
            S_WALK: begin
                case (stat.req)
                    REQ_SEC_TICK: begin
                        if (stat.time_hit) begin
                            if (stat.mode_off) begin
                                cmd.wr_sel = WR_FIRE;
                            end
                            state_next = S_DONE;
                        end else if (stat.idx_more) begin
                            cmd.idx_inc = 1'b1;
                            cmd.rd_sel  = RD_IDX_NEXT;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    REQ_RING_TICK: begin
                        cmd.wr_sel = WR_TICK;
                        if (stat.idx_more) begin
                            cmd.idx_inc = 1'b1;
                            cmd.rd_sel  = RD_IDX_NEXT;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    REQ_STOP: begin
                        if (stat.mode_ring) begin
                            cmd.wr_sel = WR_STOP;
                        end
                        if (stat.mode_ring && !stat.rpt) begin
                            // one-shot alarm: delete by its key
                            cmd.srch_start = 1'b1;
                            cmd.rd_sel     = RD_ZERO;
                            state_next     = S_SRCH;
                        end else if (stat.idx_more) begin
                            cmd.idx_inc = 1'b1;
                            cmd.rd_sel  = RD_IDX_NEXT;
                        end else begin
                            state_next = S_DONE;
                        end
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // resume the walk after a one-shot delete
            S_WALK_NEXT: begin
                if (stat.idx_more) begin
                    cmd.idx_inc = 1'b1;
                    cmd.rd_sel  = RD_IDX_NEXT;
                    state_next  = S_WALK;
                end else begin
                    state_next = S_DONE;
                end
            end

            // key search over used slots, first match wins
            S_SRCH: begin
                if (stat.key_hit) begin
                    if (stat.req == REQ_EDIT) begin
                        cmd.wr_sel = WR_EDIT;
                        state_next = S_DONE;
                    end else begin
                        cmd.rd_sel = RD_LAST;
                        state_next = S_MOVE;
                    end
                end else if (stat.srch_more) begin
                    cmd.srch_inc = 1'b1;
                    cmd.rd_sel   = RD_SRCH_NEXT;
                end else if (stat.req == REQ_STOP) begin
                    state_next = S_WALK_NEXT;
                end else begin
                    cmd.status_we = 1'b1;
                    cmd.status    = STS_NOT_FOUND;
                    state_next    = S_DONE;
                end
            end

            // last used slot fills the hole
            S_MOVE: begin
                cmd.wr_sel  = WR_MOVE;
                cmd.cnt_dec = 1'b1;
                if (stat.req == REQ_STOP) begin
                    state_next = S_WALK_NEXT;
                end else begin
                    state_next = S_DONE;
                end
            end

            S_DONE: begin
                if (stat.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/multi_alarm_snooze_controller.sv]
// channel   direction  handshake               payload
// request   in         s_tvalid / s_tready     s_tuser req_type, s_tdata operands
// result    out        m_tvalid / m_tready     m_tdata status and table summary
// config    in         cfg_valid / cfg_ready   cfg_addr register index, cfg_data value
//
// add passes through dispatch and done before its result is registered, and the
// next request is taken back in idle; delete and edit add a key search over the
// used slots, plus a move on delete.
// ticks walk the used slots one per cycle through the single-read-port slot
// ram; a second tick ends at its first match; stop adds a key search and a
// move for every one-shot alarm it deletes, which holds the walk.
// aresetn is synchronous, active low; the slot ram is not cleared, entries
// beyond the alarm count are never read.
// one finished result may wait in the output register while the next
// request is accepted; a second finished result holds until it drains.
`default_nettype none

module multi_alarm_snooze_controller
    import masc_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // request
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // alarm_key, alarm_time, alarm_active,
                                                 // alarm_repeat, current_time, zero pad
    input  wire logic [S_TUSER_W-1:0]  s_tuser,  // req_type
    // result
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,  // status, buzzer_on, fired, fired_slot,
                                                 // used_slots, zero pad
    // configuration
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // configuration writes are registered while cfg_valid is high, none taken during reset
    assign cfg_ready = aresetn;

    masc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    masc_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

[rtl/core/masc_checker.sv]
`default_nettype none

module masc_checker
    import masc_pkg::*;
#(
    parameter int SLOTS = 8
) (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    res_t res;

    assign res = res_t'(m_tdata);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // only one request in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another is in work");

    // a fired alarm means ok status and buzzer on
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.fired |-> res.status == STS_OK && res.buzzer_on)
        else $error("fired result without ok status or buzzer");

    // table full only with every slot used
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status == STS_FULL |-> res.used_slots == 4'(SLOTS))
        else $error("table full reported with free slots");

    // table empty only with no slot used
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res.status == STS_EMPTY |-> res.used_slots == 4'd0)
        else $error("table empty reported with used slots");

endmodule

bind multi_alarm_snooze_controller masc_checker #(
    .SLOTS (SLOTS)
) u_masc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
